// ===== rtl/memory_region_map_allocator_unit_assert.svh =====
// Assertion macros used by the checker file of the region map block.
`ifndef MEMORY_REGION_MAP_ALLOCATOR_UNIT_ASSERT_SVH
`define MEMORY_REGION_MAP_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, idle while reset is asserted.
`define MRMA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("region map assertion failed");

// Next-cycle implication, idle while reset is asserted.
`define MRMA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("region map assertion failed");

`endif

// ===== rtl/mrma_pkg.sv =====
`timescale 1ns / 1ps

package mrma_pkg;

    localparam int MAX_REGIONS_DEF = 128;
    localparam logic [63:0] LOW_MEMORY_TOP = 64'h0000_0000_000F_FFFF;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_AVAILABLE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOCATION = 1'b1;
    localparam logic [7:0] AVAILABLE_RESET  = 8'd1;
    localparam logic [7:0] ALLOCATION_RESET = 8'd6;

    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_CLEAN  = 3'd1,
        OP_ALLOC  = 3'd2,
        OP_FREE   = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef struct packed {
        logic [63:0] start;
        logic [63:0] length;
        logic [7:0]  kind;
    } region_t;

    typedef struct packed {
        logic [2:0]  operation;
        logic [63:0] address;
        logic [63:0] size;
        logic [7:0]  region_type;
        logic [31:0] alignment;
        logic [63:0] top_limit;
        logic [6:0]  entry_index;
    } in_item_t;

    typedef struct packed {
        logic        ok;
        logic [63:0] result_address;
        logic [63:0] result_size;
        logic [7:0]  result_type;
        logic [7:0]  entry_count;
    } out_item_t;

    typedef enum logic [5:0] {
        CMD_NONE,
        CMD_SET_OK,
        CMD_APPEND,
        CMD_RD_IDX,
        CMD_RD_CAP,
        CMD_EMIT,
        CMD_K_CLR,
        CMD_K_ONE,
        CMD_K_INC,
        CMD_RD_K,
        CMD_RD_K1,
        CMD_DROP_WR,
        CMD_DROP_DONE,
        CMD_TMP_CAP,
        CMD_RD_J1,
        CMD_WR_J_TMP,
        CMD_WR_J_RD,
        CMD_MG_INIT,
        CMD_RD_R,
        CMD_CUR_CAP,
        CMD_NXT_CAP,
        CMD_NXT_NONE,
        CMD_POP_RD,
        CMD_POP_CAP,
        CMD_SHIFT,
        CMD_PUSH_END,
        CMD_TOPS,
        CMD_PUSH_SHIFT,
        CMD_MERGE,
        CMD_OVL,
        CMD_TRIM,
        CMD_SET_COUNT,
        CMD_AL_CAP,
        CMD_AL_BASE,
        CMD_AL_TAKE,
        CMD_AL_APP
    } dp_cmd_t;

    typedef struct packed {
        logic    load;
        dp_cmd_t act;
    } ctrl_t;

    typedef struct packed {
        op_t  op;
        logic full;
        logic size_zero;
        logic idx_ok;
        logic k_lt;
        logic k1_lt;
        logic j_zero;
        logic rd_match;
        logic rd_gt;
        logic r_lt;
        logic cur_v;
        logic cur_zero;
        logic nxt_v;
        logic w_zero;
        logic lt;
        logic same;
        logic is_alloc;
        logic ovl_zero;
        logic al_fit;
        logic out_full;
    } status_t;

endpackage

// ===== rtl/mrma_channels.sv =====
`timescale 1ns / 1ps

interface mrma_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [63:0] address;
    logic [63:0] size;
    logic [7:0]  region_type;
    logic [31:0] alignment;
    logic [63:0] top_limit;
    logic [6:0]  entry_index;

    modport source (output valid, operation, address, size, region_type, alignment,
                    top_limit, entry_index, input ready);
    modport sink (input valid, operation, address, size, region_type, alignment,
                  top_limit, entry_index, output ready);
endinterface

interface mrma_out_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [63:0] result_address;
    logic [63:0] result_size;
    logic [7:0]  result_type;
    logic [7:0]  entry_count;

    modport source (output valid, ok, result_address, result_size, result_type,
                    entry_count, input ready);
    modport sink (input valid, ok, result_address, result_size, result_type,
                  entry_count, output ready);
endinterface

// ===== rtl/memory_region_map_allocator_unit.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Handshake     Payload
// in_ch     in   valid/ready   operation, address, size, region_type, alignment,
//                              top_limit, entry_index
// out_ch    out  valid/ready   ok, result_address, result_size, result_type, entry_count
// cfg       in   cfg_write     cfg_index, cfg_data
//
// One item at a time; N is the entry count.
// Clean: an insertion sort of the N entries, then a merge pass over them.
// Free adds a scan and a gap close; allocate adds a scan.
// The region memory has a registered read, so each loop reads and captures in separate states.
// Reset clears the count and control only; entries read as written.
// A new item is taken while the last result still waits; it finishes only once
// that result has been taken.

module memory_region_map_allocator_unit
#(
    parameter int MAX_REGIONS = mrma_pkg::MAX_REGIONS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    mrma_in_if.sink                         in_ch,
    mrma_out_if.source                      out_ch,
    input  logic                            cfg_write,
    input  logic [mrma_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mrma_pkg::CFG_DATA_W-1:0] cfg_data
);

    mrma_pkg::ctrl_t     ctrl;
    mrma_pkg::status_t   st;
    mrma_pkg::in_item_t  in_item;
    mrma_pkg::out_item_t out_item;
    logic                ready;

    // gather the input item into one word
    assign in_item = '{operation: in_ch.operation, address: in_ch.address,
                       size: in_ch.size, region_type: in_ch.region_type,
                       alignment: in_ch.alignment, top_limit: in_ch.top_limit,
                       entry_index: in_ch.entry_index};
    assign in_ch.ready = ready;

    // sequencer: decides every step of the sort, merge, scan and shift loops
    mrma_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (ready),
        .st       (st),
        .ctrl     (ctrl)
    );

    // region memory, working registers, adders and compares, result register
    mrma_datapath #(.MAX_REGIONS(MAX_REGIONS)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .st        (st),
        .in_item   (in_item),
        .out_item  (out_item),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // drive the result channel from the held result register
    assign out_ch.ok             = out_item.ok;
    assign out_ch.result_address = out_item.result_address;
    assign out_ch.result_size    = out_item.result_size;
    assign out_ch.result_type    = out_item.result_type;
    assign out_ch.entry_count    = out_item.entry_count;

endmodule

// ===== rtl/mrma_ctrl.sv =====
`timescale 1ns / 1ps

module mrma_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  mrma_pkg::status_t  st,
    output mrma_pkg::ctrl_t    ctrl
);

    typedef enum logic [5:0] {
        S_IDLE, S_DISPATCH, S_APPEND, S_RD_ISSUE, S_RD_CAP, S_FIN,
        S_FR_INIT, S_FR_SCAN, S_FR_CMP, S_DROP, S_DROP_WR,
        S_SORT_INIT, S_SORT_K, S_SORT_KD, S_SORT_J, S_SORT_JD,
        S_MG_INIT, S_MG_LC, S_MG_LCC, S_MG_LN, S_MG_LNC, S_MG_EVAL, S_MG_POPC,
        S_MG_CMP, S_MG_OVL, S_MG_PUSH, S_MG_END,
        S_AL_INIT, S_AL_SCAN, S_AL_CAP, S_AL_CHK, S_AL_DEC, S_AL_APP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ctrl.load  = 1'b0;
        ctrl.act   = mrma_pkg::CMD_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (st.op)
                    mrma_pkg::OP_APPEND: state_next = st.full ? S_FIN : S_APPEND;
                    mrma_pkg::OP_CLEAN:
                    begin
                        ctrl.act   = mrma_pkg::CMD_SET_OK;
                        state_next = S_SORT_INIT;
                    end
                    mrma_pkg::OP_ALLOC:
                        state_next = (st.size_zero || st.full) ? S_FIN : S_AL_INIT;
                    mrma_pkg::OP_FREE:   state_next = S_FR_INIT;
                    mrma_pkg::OP_READ:   state_next = st.idx_ok ? S_RD_ISSUE : S_FIN;
                    default:             state_next = S_FIN;
                endcase
            end
            S_APPEND:
            begin
                ctrl.act   = mrma_pkg::CMD_APPEND;
                state_next = S_FIN;
            end
            S_RD_ISSUE:
            begin
                ctrl.act   = mrma_pkg::CMD_RD_IDX;
                state_next = S_RD_CAP;
            end
            S_RD_CAP:
            begin
                ctrl.act   = mrma_pkg::CMD_RD_CAP;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!st.out_full)
                begin
                    ctrl.act   = mrma_pkg::CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            // free: find the first exact start; if found, close the gap, then clean
            S_FR_INIT:
            begin
                ctrl.act   = mrma_pkg::CMD_K_CLR;
                state_next = S_FR_SCAN;
            end
            S_FR_SCAN:
            begin
                if (!st.k_lt)
                    state_next = S_FIN;
                else
                begin
                    ctrl.act   = mrma_pkg::CMD_RD_K;
                    state_next = S_FR_CMP;
                end
            end
            S_FR_CMP:
            begin
                if (st.rd_match)
                    state_next = S_DROP;
                else
                begin
                    ctrl.act   = mrma_pkg::CMD_K_INC;
                    state_next = S_FR_SCAN;
                end
            end
            S_DROP:
            begin
                if (!st.k1_lt)
                begin
                    ctrl.act   = mrma_pkg::CMD_DROP_DONE;
                    state_next = S_SORT_INIT;
                end
                else
                begin
                    ctrl.act   = mrma_pkg::CMD_RD_K1;
                    state_next = S_DROP_WR;
                end
            end
            S_DROP_WR:
            begin
                ctrl.act   = mrma_pkg::CMD_DROP_WR;
                state_next = S_DROP;
            end
            // stable insertion sort by start
            S_SORT_INIT:
            begin
                ctrl.act   = mrma_pkg::CMD_K_ONE;
                state_next = S_SORT_K;
            end
            S_SORT_K:
            begin
                if (!st.k_lt)
                    state_next = S_MG_INIT;
                else
                begin
                    ctrl.act   = mrma_pkg::CMD_RD_K;
                    state_next = S_SORT_KD;
                end
            end
            S_SORT_KD:
            begin
                ctrl.act   = mrma_pkg::CMD_TMP_CAP;
                state_next = S_SORT_J;
            end
            S_SORT_J:
            begin
                if (st.j_zero)
                begin
                    ctrl.act   = mrma_pkg::CMD_WR_J_TMP;
                    state_next = S_SORT_K;
                end
                else
                begin
                    ctrl.act   = mrma_pkg::CMD_RD_J1;
                    state_next = S_SORT_JD;
                end
            end
            S_SORT_JD:
            begin
                if (st.rd_gt)
                begin
                    ctrl.act   = mrma_pkg::CMD_WR_J_RD;
                    state_next = S_SORT_J;
                end
                else
                begin
                    ctrl.act   = mrma_pkg::CMD_WR_J_TMP;
                    state_next = S_SORT_K;
                end
            end
            // merge pass: finished prefix in memory, current and next held
            S_MG_INIT:
            begin
                ctrl.act   = mrma_pkg::CMD_MG_INIT;
                state_next = S_MG_LC;
            end
            S_MG_LC:
            begin
                if (!st.r_lt)
                    state_next = S_MG_END;
                else
                begin
                    ctrl.act   = mrma_pkg::CMD_RD_R;
                    state_next = S_MG_LCC;
                end
            end
            S_MG_LCC:
            begin
                ctrl.act   = mrma_pkg::CMD_CUR_CAP;
                state_next = S_MG_LN;
            end
            S_MG_LN:
            begin
                if (!st.r_lt)
                begin
                    ctrl.act   = mrma_pkg::CMD_NXT_NONE;
                    state_next = S_MG_EVAL;
                end
                else
                begin
                    ctrl.act   = mrma_pkg::CMD_RD_R;
                    state_next = S_MG_LNC;
                end
            end
            S_MG_LNC:
            begin
                ctrl.act   = mrma_pkg::CMD_NXT_CAP;
                state_next = S_MG_EVAL;
            end
            S_MG_EVAL:
            begin
                if (!st.cur_v)
                    state_next = S_MG_END;
                else if (st.cur_zero)
                begin
                    if (st.w_zero)
                    begin
                        ctrl.act   = mrma_pkg::CMD_SHIFT;
                        state_next = S_MG_LN;
                    end
                    else
                    begin
                        ctrl.act   = mrma_pkg::CMD_POP_RD;
                        state_next = S_MG_POPC;
                    end
                end
                else if (!st.nxt_v)
                begin
                    ctrl.act   = mrma_pkg::CMD_PUSH_END;
                    state_next = S_MG_END;
                end
                else
                begin
                    ctrl.act   = mrma_pkg::CMD_TOPS;
                    state_next = S_MG_CMP;
                end
            end
            S_MG_POPC:
            begin
                ctrl.act   = mrma_pkg::CMD_POP_CAP;
                state_next = S_MG_EVAL;
            end
            S_MG_CMP:
            begin
                if (st.lt || (st.same && st.is_alloc))
                begin
                    ctrl.act   = mrma_pkg::CMD_PUSH_SHIFT;
                    state_next = S_MG_LN;
                end
                else if (st.same)
                begin
                    ctrl.act   = mrma_pkg::CMD_MERGE;
                    state_next = S_MG_LN;
                end
                else
                begin
                    ctrl.act   = mrma_pkg::CMD_OVL;
                    state_next = S_MG_OVL;
                end
            end
            S_MG_OVL:
            begin
                if (st.ovl_zero)
                begin
                    ctrl.act   = mrma_pkg::CMD_PUSH_SHIFT;
                    state_next = S_MG_LN;
                end
                else
                begin
                    ctrl.act   = mrma_pkg::CMD_TRIM;
                    state_next = S_MG_PUSH;
                end
            end
            S_MG_PUSH:
            begin
                ctrl.act   = mrma_pkg::CMD_PUSH_SHIFT;
                state_next = S_MG_LN;
            end
            S_MG_END:
            begin
                ctrl.act   = mrma_pkg::CMD_SET_COUNT;
                state_next = S_FIN;
            end
            // allocate: first fitting available region in table order
            S_AL_INIT:
            begin
                ctrl.act   = mrma_pkg::CMD_K_CLR;
                state_next = S_AL_SCAN;
            end
            S_AL_SCAN:
            begin
                if (!st.k_lt)
                    state_next = S_FIN;
                else
                begin
                    ctrl.act   = mrma_pkg::CMD_RD_K;
                    state_next = S_AL_CAP;
                end
            end
            S_AL_CAP:
            begin
                ctrl.act   = mrma_pkg::CMD_AL_CAP;
                state_next = S_AL_CHK;
            end
            S_AL_CHK:
            begin
                ctrl.act   = mrma_pkg::CMD_AL_BASE;
                state_next = S_AL_DEC;
            end
            S_AL_DEC:
            begin
                if (st.al_fit)
                begin
                    ctrl.act   = mrma_pkg::CMD_AL_TAKE;
                    state_next = S_AL_APP;
                end
                else
                begin
                    ctrl.act   = mrma_pkg::CMD_K_INC;
                    state_next = S_AL_SCAN;
                end
            end
            S_AL_APP:
            begin
                ctrl.act   = mrma_pkg::CMD_AL_APP;
                state_next = S_SORT_INIT;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/mrma_datapath.sv =====
`timescale 1ns / 1ps

module mrma_datapath
#(
    parameter int MAX_REGIONS = mrma_pkg::MAX_REGIONS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  mrma_pkg::ctrl_t                     ctrl,
    output mrma_pkg::status_t                   st,
    input  mrma_pkg::in_item_t                  in_item,
    output mrma_pkg::out_item_t                 out_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                cfg_write,
    input  logic [mrma_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mrma_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CW = $clog2(MAX_REGIONS + 1);
    localparam int IW = (CW > 7) ? CW : 7;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_REGIONS);

    mrma_pkg::region_t region_mem [MAX_REGIONS];
    mrma_pkg::region_t rdata_reg;

    // control state
    logic [CW-1:0] count_reg;
    logic          out_valid_reg;
    logic [7:0]    avail_reg;
    logic [7:0]    alloc_reg;
    logic          cur_v_reg;
    logic          nxt_v_reg;

    // payload state
    mrma_pkg::op_t     op_reg;
    logic [63:0]       addr_reg;
    logic [63:0]       size_reg;
    logic [7:0]        type_reg;
    logic [31:0]       mask_reg;
    logic [63:0]       limit_reg;
    logic [6:0]        idx_reg;
    logic [CW-1:0]     k_reg;
    logic [CW-1:0]     j_reg;
    logic [CW-1:0]     w_reg;
    logic [CW-1:0]     r_reg;
    mrma_pkg::region_t tmp_reg;
    mrma_pkg::region_t cur_reg;
    mrma_pkg::region_t nxt_reg;
    logic [63:0]       top_reg;
    logic [63:0]       ntop_reg;
    logic [63:0]       ovl_reg;
    logic [63:0]       etop_reg;
    logic [63:0]       base_reg;
    logic              al_ok_reg;
    logic              ok_w_reg;
    logic [63:0]       raddr_w_reg;
    logic [63:0]       rsize_w_reg;
    logic [7:0]        rtype_w_reg;
    mrma_pkg::out_item_t out_reg;

    logic [CW-1:0] k_inc;
    logic [CW-1:0] j_dec;
    logic [CW-1:0] w_dec;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    mrma_pkg::region_t wr_data;
    logic [63:0]   merge_top;

    function automatic logic [CW-1:0] k_inc_count(input logic [CW-1:0] v);
        return v + 1'b1;
    endfunction

    assign k_inc = k_reg + 1'b1;
    assign j_dec = j_reg - 1'b1;
    assign w_dec = w_reg - 1'b1;
    assign merge_top = (top_reg > ntop_reg) ? top_reg : ntop_reg;

    always_comb
    begin
        rd_en   = 1'b1;
        rd_addr = k_reg[AW-1:0];
        case (ctrl.act)
            mrma_pkg::CMD_RD_IDX: rd_addr = AW'(idx_reg);
            mrma_pkg::CMD_RD_K:   rd_addr = k_reg[AW-1:0];
            mrma_pkg::CMD_RD_K1:  rd_addr = k_inc[AW-1:0];
            mrma_pkg::CMD_RD_J1:  rd_addr = j_dec[AW-1:0];
            mrma_pkg::CMD_RD_R:   rd_addr = r_reg[AW-1:0];
            mrma_pkg::CMD_POP_RD: rd_addr = w_dec[AW-1:0];
            default:              rd_en   = 1'b0;
        endcase
    end

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = count_reg[AW-1:0];
        wr_data = '{start: addr_reg, length: size_reg, kind: type_reg};
        case (ctrl.act)
            mrma_pkg::CMD_APPEND: ;
            mrma_pkg::CMD_DROP_WR:
            begin
                wr_addr = k_reg[AW-1:0];
                wr_data = rdata_reg;
            end
            mrma_pkg::CMD_WR_J_TMP:
            begin
                wr_addr = j_reg[AW-1:0];
                wr_data = tmp_reg;
            end
            mrma_pkg::CMD_WR_J_RD:
            begin
                wr_addr = j_reg[AW-1:0];
                wr_data = rdata_reg;
            end
            mrma_pkg::CMD_PUSH_END, mrma_pkg::CMD_PUSH_SHIFT:
            begin
                wr_addr = w_reg[AW-1:0];
                wr_data = cur_reg;
            end
            mrma_pkg::CMD_AL_TAKE:
            begin
                // start + length wraps to the region end, so the kept length is base - start
                wr_addr = k_reg[AW-1:0];
                wr_data = '{start: cur_reg.start, length: base_reg - cur_reg.start,
                            kind: cur_reg.kind};
            end
            mrma_pkg::CMD_AL_APP:
                wr_data = '{start: base_reg, length: size_reg, kind: type_reg};
            default:
                wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            region_mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= region_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            avail_reg     <= mrma_pkg::AVAILABLE_RESET;
            alloc_reg     <= mrma_pkg::ALLOCATION_RESET;
            cur_v_reg     <= 1'b0;
            nxt_v_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    mrma_pkg::CFG_AVAILABLE:  avail_reg <= cfg_data;
                    mrma_pkg::CFG_ALLOCATION: alloc_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (ctrl.act == mrma_pkg::CMD_EMIT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (ctrl.act)
                mrma_pkg::CMD_APPEND, mrma_pkg::CMD_AL_APP: count_reg <= k_inc_count(count_reg);
                mrma_pkg::CMD_DROP_DONE: count_reg <= count_reg - 1'b1;
                mrma_pkg::CMD_SET_COUNT: count_reg <= w_reg;
                mrma_pkg::CMD_MG_INIT:
                begin
                    cur_v_reg <= 1'b0;
                    nxt_v_reg <= 1'b0;
                end
                mrma_pkg::CMD_CUR_CAP, mrma_pkg::CMD_POP_CAP: cur_v_reg <= 1'b1;
                mrma_pkg::CMD_SHIFT, mrma_pkg::CMD_PUSH_SHIFT: cur_v_reg <= nxt_v_reg;
                mrma_pkg::CMD_PUSH_END: cur_v_reg <= 1'b0;
                mrma_pkg::CMD_NXT_CAP:  nxt_v_reg <= 1'b1;
                mrma_pkg::CMD_NXT_NONE: nxt_v_reg <= 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            op_reg      <= mrma_pkg::op_t'(in_item.operation);
            addr_reg    <= in_item.address;
            size_reg    <= in_item.size;
            type_reg    <= in_item.region_type;
            mask_reg    <= (in_item.alignment == '0) ? '0 : in_item.alignment - 32'd1;
            limit_reg   <= (in_item.top_limit == '0) ? '1 : in_item.top_limit;
            idx_reg     <= in_item.entry_index;
            ok_w_reg    <= 1'b0;
            raddr_w_reg <= '0;
            rsize_w_reg <= '0;
            rtype_w_reg <= '0;
        end
        case (ctrl.act)
            mrma_pkg::CMD_SET_OK, mrma_pkg::CMD_APPEND, mrma_pkg::CMD_DROP_DONE:
                ok_w_reg <= 1'b1;
            mrma_pkg::CMD_RD_CAP:
            begin
                ok_w_reg    <= 1'b1;
                raddr_w_reg <= rdata_reg.start;
                rsize_w_reg <= rdata_reg.length;
                rtype_w_reg <= rdata_reg.kind;
            end
            mrma_pkg::CMD_EMIT:
                out_reg <= '{ok: ok_w_reg, result_address: raddr_w_reg,
                             result_size: rsize_w_reg, result_type: rtype_w_reg,
                             entry_count: 8'(count_reg)};
            mrma_pkg::CMD_K_CLR:    k_reg <= '0;
            mrma_pkg::CMD_K_ONE:    k_reg <= CW'(1);
            mrma_pkg::CMD_K_INC, mrma_pkg::CMD_DROP_WR, mrma_pkg::CMD_WR_J_TMP:
                k_reg <= k_inc;
            mrma_pkg::CMD_TMP_CAP:
            begin
                tmp_reg <= rdata_reg;
                j_reg   <= k_reg;
            end
            mrma_pkg::CMD_WR_J_RD:  j_reg <= j_dec;
            mrma_pkg::CMD_MG_INIT:
            begin
                w_reg <= '0;
                r_reg <= '0;
            end
            mrma_pkg::CMD_CUR_CAP:
            begin
                cur_reg <= rdata_reg;
                r_reg   <= r_reg + 1'b1;
            end
            mrma_pkg::CMD_NXT_CAP:
            begin
                nxt_reg <= rdata_reg;
                r_reg   <= r_reg + 1'b1;
            end
            mrma_pkg::CMD_POP_RD:   w_reg <= w_dec;
            mrma_pkg::CMD_POP_CAP:  cur_reg <= rdata_reg;
            mrma_pkg::CMD_SHIFT:    cur_reg <= nxt_reg;
            mrma_pkg::CMD_PUSH_END: w_reg <= w_reg + 1'b1;
            mrma_pkg::CMD_PUSH_SHIFT:
            begin
                w_reg   <= w_reg + 1'b1;
                cur_reg <= nxt_reg;
            end
            mrma_pkg::CMD_TOPS:
            begin
                top_reg  <= cur_reg.start + cur_reg.length;
                ntop_reg <= nxt_reg.start + nxt_reg.length;
            end
            mrma_pkg::CMD_MERGE:    cur_reg.length <= merge_top - cur_reg.start;
            mrma_pkg::CMD_OVL:      ovl_reg <= top_reg - nxt_reg.start;
            mrma_pkg::CMD_TRIM:
            begin
                if (cur_reg.kind > nxt_reg.kind)
                begin
                    nxt_reg.start  <= nxt_reg.start + ovl_reg;
                    nxt_reg.length <= (ovl_reg >= nxt_reg.length) ? '0
                                      : nxt_reg.length - ovl_reg;
                end
                else
                    cur_reg.length <= (ovl_reg >= cur_reg.length) ? '0
                                      : cur_reg.length - ovl_reg;
            end
            mrma_pkg::CMD_AL_CAP:
            begin
                cur_reg  <= rdata_reg;
                etop_reg <= rdata_reg.start + rdata_reg.length;
            end
            mrma_pkg::CMD_AL_BASE:
            begin
                base_reg  <= (etop_reg - size_reg) & ~{32'd0, mask_reg};
                al_ok_reg <= (cur_reg.kind == avail_reg) && (cur_reg.length >= size_reg)
                             && (etop_reg < limit_reg)
                             && !((limit_reg > mrma_pkg::LOW_MEMORY_TOP)
                                  && (etop_reg <= mrma_pkg::LOW_MEMORY_TOP));
            end
            mrma_pkg::CMD_AL_TAKE:
            begin
                ok_w_reg    <= 1'b1;
                raddr_w_reg <= base_reg;
            end
            default: ;
        endcase
    end

    assign st.op        = op_reg;
    assign st.full      = (count_reg >= MAX_CNT);
    assign st.size_zero = (size_reg == '0);
    assign st.idx_ok    = (IW'(idx_reg) < IW'(count_reg));
    assign st.k_lt      = (k_reg < count_reg);
    assign st.k1_lt     = (k_inc < count_reg);
    assign st.j_zero    = (j_reg == '0);
    assign st.rd_match  = (rdata_reg.start == addr_reg);
    assign st.rd_gt     = (rdata_reg.start > tmp_reg.start);
    assign st.r_lt      = (r_reg < count_reg);
    assign st.cur_v     = cur_v_reg;
    assign st.cur_zero  = (cur_reg.length == '0);
    assign st.nxt_v     = nxt_v_reg;
    assign st.w_zero    = (w_reg == '0);
    assign st.lt        = (top_reg < nxt_reg.start);
    assign st.same      = (cur_reg.kind == nxt_reg.kind);
    assign st.is_alloc  = (cur_reg.kind == alloc_reg);
    assign st.ovl_zero  = (ovl_reg == '0);
    assign st.al_fit    = al_ok_reg && (base_reg >= cur_reg.start);
    assign st.out_full  = out_valid_reg;

    assign out_item  = out_reg;
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/mrma_checker.sv =====
`timescale 1ns / 1ps
`include "memory_region_map_allocator_unit_assert.svh"

module mrma_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        out_ok,
    input logic [63:0] out_address,
    input logic [63:0] out_size,
    input logic [7:0]  out_type
);

    `MRMA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `MRMA_ASSERT_NOW(a_fail_zero, clk, rst_n, out_valid && !out_ok, (out_address == 64'd0) && (out_size == 64'd0) && (out_type == 8'd0))
    `MRMA_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready)
    `MRMA_ASSERT_NEXT(a_no_instant_result, clk, rst_n, in_valid && in_ready, !$rose(out_valid))

endmodule

bind memory_region_map_allocator_unit mrma_checker u_mrma_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_ok      (out_ch.ok),
    .out_address (out_ch.result_address),
    .out_size    (out_ch.result_size),
    .out_type    (out_ch.result_type)
);

// ===== tb/sv/memory_region_map_allocator_unit_checker.sv =====
`timescale 1ns / 1ps

module memory_region_map_allocator_unit_checker
    import mrma_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    mrma_in_if                     in_ch,
    mrma_out_if                    out_ch,
    input  logic                   cfg_write,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     failures,
    output int                     awaiting
);

    logic [63:0] map_start [MAX_REGIONS_DEF];
    logic [63:0] map_len   [MAX_REGIONS_DEF];
    logic [7:0]  map_kind  [MAX_REGIONS_DEF];
    int          map_used;
    logic [7:0]  usable_code;
    logic [7:0]  carved_code;
    out_item_t   result_q [$];

    function automatic void remove_region(int pos);
        if (pos >= map_used)
            return;
        map_used--;
        for (int k = pos; k < map_used; k++)
        begin
            map_start[k] = map_start[k+1];
            map_len[k]   = map_len[k+1];
            map_kind[k]  = map_kind[k+1];
        end
    endfunction

    function automatic void sort_map();
        logic [63:0] s;
        logic [63:0] l;
        logic [7:0]  t;
        int          j;
        for (int k = 1; k < map_used; k++)
        begin
            s = map_start[k];
            l = map_len[k];
            t = map_kind[k];
            j = k;
            while (j > 0 && map_start[j-1] > s)
            begin
                map_start[j] = map_start[j-1];
                map_len[j]   = map_len[j-1];
                map_kind[j]  = map_kind[j-1];
                j--;
            end
            map_start[j] = s;
            map_len[j]   = l;
            map_kind[j]  = t;
        end
    endfunction

    // sort, drop empties, merge touching equal neighbours unless carved, let the higher code win overlaps
    function automatic void tidy_map();
        int          i;
        logic [63:0] top_a;
        logic [63:0] top_b;
        logic [63:0] ovl;
        i = 0;
        sort_map();
        while (i < map_used)
        begin
            if (map_len[i] == 0)
            begin
                remove_region(i);
                if (i > 0)
                    i--;
                continue;
            end
            if (i + 1 >= map_used)
            begin
                i++;
                continue;
            end
            top_a = map_start[i] + map_len[i];
            if (top_a < map_start[i+1])
            begin
                i++;
                continue;
            end
            if (map_kind[i] == map_kind[i+1])
            begin
                if (map_kind[i] == carved_code)
                begin
                    i++;
                    continue;
                end
                top_b = map_start[i+1] + map_len[i+1];
                if (top_a > top_b)
                    top_b = top_a;
                map_start[i+1] = map_start[i];
                map_len[i+1]   = top_b - map_start[i];
                remove_region(i);
                continue;
            end
            ovl = top_a - map_start[i+1];
            if (ovl != 0)
            begin
                if (map_kind[i] > map_kind[i+1])
                begin
                    map_start[i+1] += ovl;
                    map_len[i+1] = (ovl >= map_len[i+1]) ? 64'd0 : map_len[i+1] - ovl;
                end
                else
                    map_len[i] = (ovl >= map_len[i]) ? 64'd0 : map_len[i] - ovl;
            end
            i++;
        end
    endfunction

    function automatic void add_region(logic [63:0] s, logic [63:0] l, logic [7:0] t);
        map_start[map_used] = s;
        map_len[map_used]   = l;
        map_kind[map_used]  = t;
        map_used++;
    endfunction

    function automatic bit carve(in_item_t it, output logic [63:0] base);
        logic [63:0] al;
        logic [63:0] lim;
        logic [63:0] etop;
        base = '0;
        if (it.size == 0 || map_used >= MAX_REGIONS_DEF)
            return 1'b0;
        al  = (it.alignment == 0) ? 64'd1 : {32'd0, it.alignment};
        lim = (it.top_limit == 0) ? '1 : it.top_limit;
        for (int i = 0; i < map_used; i++)
        begin
            if (map_kind[i] != usable_code || map_len[i] < it.size)
                continue;
            etop = map_start[i] + map_len[i];
            if (etop >= lim)
                continue;
            if (lim > LOW_MEMORY_TOP && etop <= LOW_MEMORY_TOP)
                continue;
            base = (etop - it.size) & ~(al - 64'd1);
            if (base < map_start[i])
                continue;
            map_len[i] -= etop - base;
            add_region(base, it.size, it.region_type);
            tidy_map();
            return 1'b1;
        end
        base = '0;
        return 1'b0;
    endfunction

    function automatic out_item_t apply_op(in_item_t it);
        out_item_t   r;
        logic [63:0] base;
        r = '0;
        case (it.operation)
            OP_APPEND:
                if (map_used < MAX_REGIONS_DEF)
                begin
                    add_region(it.address, it.size, it.region_type);
                    r.ok = 1'b1;
                end
            OP_CLEAN:
            begin
                tidy_map();
                r.ok = 1'b1;
            end
            OP_ALLOC:
                if (carve(it, base))
                begin
                    r.ok = 1'b1;
                    r.result_address = base;
                end
            OP_FREE:
                for (int i = 0; i < map_used; i++)
                    if (map_start[i] == it.address)
                    begin
                        remove_region(i);
                        tidy_map();
                        r.ok = 1'b1;
                        break;
                    end
            OP_READ:
                if (it.entry_index < map_used)
                begin
                    r.ok = 1'b1;
                    r.result_address = map_start[it.entry_index];
                    r.result_size    = map_len[it.entry_index];
                    r.result_type    = map_kind[it.entry_index];
                end
            default: ;
        endcase
        r.entry_count = map_used[7:0];
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t mismatch %s: expected %h actual %h", $realtime, name, exp_v, act_v);
            failures++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        in_item_t  it;
        out_item_t want;
        if (!rst_n)
        begin
            map_used    = 0;
            usable_code = AVAILABLE_RESET;
            carved_code = ALLOCATION_RESET;
            result_q.delete();
            failures    = 0;
            awaiting    = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t unexpected result item: ok %b count %0d", $realtime,
                             out_ch.ok, out_ch.entry_count);
                    failures++;
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("ok", want.ok, out_ch.ok);
                    check_field("result_address", want.result_address, out_ch.result_address);
                    check_field("result_size", want.result_size, out_ch.result_size);
                    check_field("result_type", want.result_type, out_ch.result_type);
                    check_field("entry_count", want.entry_count, out_ch.entry_count);
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                it.operation   = in_ch.operation;
                it.address     = in_ch.address;
                it.size        = in_ch.size;
                it.region_type = in_ch.region_type;
                it.alignment   = in_ch.alignment;
                it.top_limit   = in_ch.top_limit;
                it.entry_index = in_ch.entry_index;
                result_q.push_back(apply_op(it));
            end
            if (cfg_write)
            begin
                if (cfg_index == CFG_AVAILABLE)
                    usable_code = cfg_data;
                else
                    carved_code = cfg_data;
            end
            awaiting = result_q.size();
        end
    end

endmodule

// ===== tb/sv/memory_region_map_allocator_unit_test.sv =====
`timescale 1ns / 1ps

module memory_region_map_allocator_unit_test;
    import mrma_pkg::*;

    // cycles without any handshake before the run is declared hung
    localparam int STALL_LIMIT = 300000;
    localparam int RANDOM_ITEMS = 900;

    logic clk;
    logic rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mrma_in_if  in_ch ();
    mrma_out_if out_ch ();

    int          failures;
    int          awaiting;
    bit          quiet;        // no idling on either side while set
    bit          hold_go;      // ask the receiver for one long hold-off
    int          last_count;
    logic [63:0] last_addr;
    logic [7:0]  cur_avail;
    logic [7:0]  cur_alloc;
    int          idle_cycles = 0;

    memory_region_map_allocator_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    memory_region_map_allocator_unit_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .failures  (failures),
        .awaiting  (awaiting)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: count cycles in which neither channel moves an item
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("FAIL memory_region_map_allocator_unit");
            $finish;
        end
    end

    // Receiver: random back-pressure, one long hold-off on request, and note the
    // last result so that the sender can pick real region starts to free
    initial
    begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                last_count = out_ch.entry_count;
                last_addr  = out_ch.result_address;
            end
            if (hold_go)
            begin
                hold_go = 1'b0;
                out_ch.ready <= 1'b0;
                // hold for a long stretch while the sender keeps offering items
                repeat (600) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 30);
                @(posedge clk);
            end
        end
    end

    // Offer one item and hold it until taken; idle gaps fall before it at random
    task automatic send(logic [2:0] op, logic [63:0] addr, logic [63:0] sz,
                        logic [7:0] rtype, logic [31:0] align, logic [63:0] lim,
                        logic [6:0] idx);
        while (!quiet && $urandom_range(0, 99) < 30)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.operation   <= op;
        in_ch.address     <= addr;
        in_ch.size        <= sz;
        in_ch.region_type <= rtype;
        in_ch.alignment   <= align;
        in_ch.top_limit   <= lim;
        in_ch.entry_index <= idx;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        wait (awaiting == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_AVAILABLE)
            cur_avail = value;
        else
            cur_alloc = value;
    endtask

    // Most starts sit on a 4 KiB grid above low memory so that regions touch,
    // overlap and get freed by exact address
    function automatic logic [63:0] pick_addr();
        case ($urandom_range(0, 9))
            0:       return {$urandom, $urandom};
            1:       return 64'($urandom_range(0, 255)) * 64'h1000;
            default: return 64'h10_0000 + 64'($urandom_range(0, 47)) * 64'h1000;
        endcase
    endfunction

    function automatic logic [63:0] pick_size();
        case ($urandom_range(0, 11))
            0:       return 64'd0;
            1:       return {$urandom, $urandom};
            2:       return '1;
            3:       return 64'($urandom_range(1, 4095));
            default: return 64'($urandom_range(1, 16)) * 64'h1000;
        endcase
    endfunction

    function automatic logic [7:0] pick_type();
        case ($urandom_range(0, 5))
            0, 1:    return cur_avail;
            2:       return cur_alloc;
            3:       return 8'($urandom);
            default: return 8'($urandom_range(2, 4));
        endcase
    endfunction

    function automatic logic [31:0] pick_align();
        case ($urandom_range(0, 4))
            0:       return 32'd0;
            1:       return $urandom;
            2:       return 32'd1 << $urandom_range(0, 31);
            default: return 32'h1000;
        endcase
    endfunction

    function automatic logic [63:0] pick_limit();
        case ($urandom_range(0, 5))
            0:       return 64'h10_0000 + 64'($urandom_range(0, 64)) * 64'h1000;
            1:       return {$urandom, $urandom};
            2:       return '1;
            3:       return 64'($urandom_range(0, 'hfffff));
            default: return 64'd0;
        endcase
    endfunction

    // Keep the table short: read a live entry and free it by its start
    task automatic shrink();
        send(OP_READ, pick_addr(), 0, 0, 0, 0, 7'($urandom_range(0, last_count - 1)));
        drain();
        send(OP_FREE, last_addr, 0, 0, 0, 0, 0);
    endtask

    task automatic random_phase(int n);
        int pick;
        for (int k = 0; k < n; k++)
        begin
            if (last_count > 14 && $urandom_range(0, 2) == 0)
            begin
                shrink();
                continue;
            end
            pick = $urandom_range(0, 99);
            if (pick < 35)
                send(OP_APPEND, pick_addr(), pick_size(), pick_type(), $urandom, $urandom,
                     7'($urandom));
            else if (pick < 60)
                send(OP_ALLOC, $urandom, pick_size(), pick_type(), pick_align(), pick_limit(),
                     7'($urandom));
            else if (pick < 70)
                send(OP_FREE, pick_addr(), $urandom, $urandom, $urandom, $urandom, 7'($urandom));
            else if (pick < 85)
                send(OP_READ, {$urandom, $urandom}, 0, 0, 0, 0,
                     ($urandom_range(0, 3) == 0) ? 7'($urandom)
                                                 : 7'($urandom_range(0, last_count + 1)));
            else if (pick < 95)
                send(OP_CLEAN, pick_addr(), 0, 0, 0, 0, 0);
            else
                send(3'($urandom_range(5, 7)), pick_addr(), pick_size(), pick_type(), 0, 0,
                     7'($urandom));
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        cfg_write   <= 1'b0;
        cfg_index   <= CFG_AVAILABLE;
        cfg_data    <= '0;
        in_ch.valid <= 1'b0;
        in_ch.operation   <= OP_APPEND;
        in_ch.address     <= '0;
        in_ch.size        <= '0;
        in_ch.region_type <= '0;
        in_ch.alignment   <= '0;
        in_ch.top_limit   <= '0;
        in_ch.entry_index <= '0;
        quiet       = 1'b0;
        hold_go     = 1'b0;
        last_count  = 0;
        last_addr   = '0;
        cur_avail   = AVAILABLE_RESET;
        cur_alloc   = ALLOCATION_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, field extremes, every operation and corner case
        send(OP_READ, 0, 0, 0, 0, 0, 7'd0);
        send(OP_FREE, 0, 0, 0, 0, 0, 0);
        send(OP_ALLOC, 0, 64'h1000, ALLOCATION_RESET, 0, 0, 0);
        send(OP_CLEAN, 0, 0, 0, 0, 0, 0);
        send(OP_APPEND, 64'h20_0000, 0, 8'd3, 0, 0, 0);
        send(OP_APPEND, '1, '1, 8'hff, '1, '1, '1);
        send(OP_APPEND, 64'h1000, 64'h8000, AVAILABLE_RESET, 0, 0, 0);
        send(OP_APPEND, 64'h10_0000, 64'h10_0000, AVAILABLE_RESET, 0, 0, 0);
        send(OP_APPEND, 64'h18_0000, 64'h10_0000, AVAILABLE_RESET, 0, 0, 0);
        send(OP_APPEND, 64'h1F_0000, 64'h2_0000, 8'd2, 0, 0, 0);
        send(OP_APPEND, 64'h30_0000, 64'h1000, 8'd0, 0, 0, 0);
        send(OP_CLEAN, 0, 0, 0, 0, 0, 0);
        send(OP_READ, 0, 0, 0, 0, 0, 7'd1);
        send(OP_ALLOC, 0, 0, ALLOCATION_RESET, 0, 0, 0);
        send(OP_ALLOC, 0, 64'h3000, ALLOCATION_RESET, 32'h1000, 0, 0);
        send(OP_ALLOC, 0, 64'h3000, ALLOCATION_RESET, 32'h1000, 0, 0);
        send(OP_ALLOC, 0, 64'h100, ALLOCATION_RESET, 32'h3000, 64'h1C_0000, 0);
        send(OP_ALLOC, 0, 64'h800, 8'd9, 32'h8000_0000, 64'h8_0000, 0);
        send(OP_ALLOC, 0, '1, ALLOCATION_RESET, 0, 0, 0);
        send(OP_READ, 0, 0, 0, 0, 0, 7'd2);
        send(OP_READ, 0, 0, 0, 0, 0, 7'h7f);
        send(OP_FREE, 64'h20_0000, 0, 0, 0, 0, 0);
        send(OP_FREE, 64'h10_0000, 0, 0, 0, 0, 0);
        send(3'd7, '1, '1, 8'hff, '1, '1, '1);
        send(OP_CLEAN, 0, 0, 0, 0, 0, 0);
        drain();

        // Fill the table with empty regions: append, allocate and read at the
        // top, then a clean drops them all again
        for (int k = 0; k < MAX_REGIONS_DEF + 2; k++)
            send(OP_APPEND, 64'h4000_0000 + 64'(k) * 64'h10, 0, 8'(k), 0, 0, 0);
        send(OP_ALLOC, 0, 64'h100, ALLOCATION_RESET, 0, 0, 0);
        send(OP_READ, 0, 0, 0, 0, 0, 7'h7f);
        send(OP_CLEAN, 0, 0, 0, 0, 0, 0);
        drain();

        random_phase(RANDOM_ITEMS / 4);

        // Extremes of both codes; open with a long receiver hold-off
        write_reg(CFG_AVAILABLE, 8'hff);
        write_reg(CFG_ALLOCATION, 8'h00);
        hold_go = 1'b1;
        random_phase(RANDOM_ITEMS / 4);

        write_reg(CFG_AVAILABLE, 8'h00);
        write_reg(CFG_ALLOCATION, 8'hff);
        random_phase(RANDOM_ITEMS / 8);
        // sender pauses until every result is back, then carries on
        drain();
        random_phase(RANDOM_ITEMS / 8);

        write_reg(CFG_AVAILABLE, AVAILABLE_RESET);
        write_reg(CFG_ALLOCATION, ALLOCATION_RESET);
        quiet = 1'b1;
        random_phase(RANDOM_ITEMS / 8);
        quiet = 1'b0;
        random_phase(RANDOM_ITEMS / 8);

        drain();
        repeat (100) @(posedge clk);
        if (failures == 0)
            $display("PASS memory_region_map_allocator_unit");
        else
            $display("FAIL memory_region_map_allocator_unit");
        $finish;
    end

endmodule
